@@ design/riff_chunk_deframer_top_assert.svh @@
// Assertion macros shared by the deframer RTL.
`ifndef RIFF_CHUNK_DEFRAMER_TOP_ASSERT_SVH
`define RIFF_CHUNK_DEFRAMER_TOP_ASSERT_SVH

// When cond holds at a clock edge, prop must hold at the same edge.
`define RCD_ASSERT_SAME(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);

// When cond holds at a clock edge, prop must hold at the next edge.
`define RCD_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

@@ design/rcd_pkg.sv @@
package rcd_pkg;

	localparam int unsigned HdrBytes     = 8;
	localparam int unsigned ListHdrBytes = 12;
	localparam int unsigned FormBytes    = ListHdrBytes - HdrBytes;

	localparam logic [31:0] TagRiff = 32'h4646_4952;
	localparam logic [31:0] TagList = 32'h5453_494C;
	localparam logic [31:0] TagAvih = 32'h6869_7661;
	localparam logic [31:0] TagStrh = 32'h6872_7473;
	localparam logic [31:0] TagStrf = 32'h6672_7473;

	typedef enum logic [1:0] {
		KIND_MAIN_HDR   = 2'd0,
		KIND_STREAM_HDR = 2'd1,
		KIND_STREAM_FMT = 2'd2,
		KIND_DATA       = 2'd3
	} chunk_kind_t;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_FORM    = 2'd1,
		PH_PAYLOAD = 2'd2,
		PH_PAD     = 2'd3
	} parse_phase_t;

	typedef struct packed {
		chunk_kind_t chunk_kind;
		logic [31:0] chunk_tag;
		logic [31:0] chunk_length;
		logic [7:0]  payload_byte;
		logic        byte_valid;
		logic        chunk_last;
	} chunk_result_t;

	function automatic chunk_kind_t classify(input logic [31:0] tag);
		chunk_kind_t k;
		if (tag == TagAvih) begin
			k = KIND_MAIN_HDR;
		end else if (tag == TagStrh) begin
			k = KIND_STREAM_HDR;
		end else if (tag == TagStrf) begin
			k = KIND_STREAM_FMT;
		end else begin
			k = KIND_DATA;
		end
		return k;
	endfunction

endpackage

@@ design/rcd_byte_if.sv @@
interface rcd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

@@ design/rcd_chunk_if.sv @@
interface rcd_chunk_if;
	logic        valid;
	logic        ready;
	logic [1:0]  chunk_kind;
	logic [31:0] chunk_tag;
	logic [31:0] chunk_length;
	logic [7:0]  payload_byte;
	logic        byte_valid;
	logic        chunk_last;

	modport source (output valid, output chunk_kind, output chunk_tag, output chunk_length,
		output payload_byte, output byte_valid, output chunk_last, input ready);
	modport sink (input valid, input chunk_kind, input chunk_tag, input chunk_length,
		input payload_byte, input byte_valid, input chunk_last, output ready);
endinterface

@@ design/riff_chunk_deframer_top.sv @@
// RIFF chunk deframer for AVI byte streams. Bytes enter on the stream channel one
// transaction per cycle; each lands in an input register, is parsed from there
// and, if it yields a result, is placed in the output register; the sustained rate
// is one byte per cycle while the chunk channel keeps up.
// The only stall comes from the output register: a payload byte or an empty-chunk marker
// waits when the previous result has not yet been taken. Chunk header, list form-type
// and pad bytes are consumed without producing a transaction. RIFF and LIST headers
// are descended into directly; list sizes are not checked and no end of stream is
// signalled.
`include "riff_chunk_deframer_top_assert.svh"

module riff_chunk_deframer_top (
	input  logic      clk,
	input  logic      arst_n,
	rcd_byte_if.sink  stream,
	rcd_chunk_if.source chunk
);

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   produce;
	logic                   slot_free;
	logic                   advance;
	rcd_pkg::chunk_result_t result;

	assign advance      = valid_s1 && (!produce || slot_free);
	assign stream.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			byte_s1 <= stream.data_byte;
		end
	end

	rcd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (byte_s1),
		.advance   (advance),
		.produce   (produce),
		.result    (result)
	);

	rcd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && produce),
		.result    (result),
		.slot_free (slot_free),
		.chunk     (chunk)
	);

	`RCD_ASSERT_SAME(a_stall_only_on_result, clk, arst_n, valid_s1 && !advance, produce && chunk.valid && !chunk.ready, "input stage stalled without a pending result")
	`RCD_ASSERT_SAME(a_empty_is_last, clk, arst_n, chunk.valid && !chunk.byte_valid, chunk.chunk_last && chunk.chunk_length == 32'd0, "empty-chunk marker is not a final zero-length transaction")
	`RCD_ASSERT_NEXT(a_load_shows, clk, arst_n, advance && produce, chunk.valid, "loaded result not presented on the chunk channel")

endmodule

@@ design/rcd_parser.sv @@
module rcd_parser (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [7:0]             data_byte,
	input  logic                   advance,
	output logic                   produce,
	output rcd_pkg::chunk_result_t result
);

	localparam logic [2:0] LastHdrPos  = 3'(rcd_pkg::HdrBytes - 1);
	localparam logic [2:0] LastFormPos = 3'(rcd_pkg::FormBytes - 1);

	rcd_pkg::parse_phase_t phase_q, phase_d;
	rcd_pkg::chunk_kind_t  kind_q, kind_d;
	logic [2:0]            pos_q, pos_d;
	logic [31:0]           tag_q, tag_d;
	logic [31:0]           size_q, size_d;
	logic [31:0]           rem_q, rem_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rcd_pkg::PH_HEADER;
			kind_q  <= rcd_pkg::KIND_MAIN_HDR;
			pos_q   <= '0;
			tag_q   <= '0;
			size_q  <= '0;
			rem_q   <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			kind_q  <= kind_d;
			pos_q   <= pos_d;
			tag_q   <= tag_d;
			size_q  <= size_d;
			rem_q   <= rem_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		kind_d  = kind_q;
		pos_d   = pos_q;
		tag_d   = tag_q;
		size_d  = size_q;
		rem_d   = rem_q;
		produce = 1'b0;
		result.chunk_kind   = kind_q;
		result.chunk_tag    = tag_q;
		result.chunk_length = size_q;
		result.payload_byte = data_byte;
		result.byte_valid   = 1'b1;
		result.chunk_last   = 1'b0;

		case (phase_q)
			rcd_pkg::PH_HEADER: begin
				// Little-endian: byte n of the header lands in lane n mod 4.
				if (!pos_q[2]) begin
					tag_d[{pos_q[1:0], 3'b000} +: 8] = data_byte;
				end else begin
					size_d[{pos_q[1:0], 3'b000} +: 8] = data_byte;
				end
				if (pos_q != LastHdrPos) begin
					pos_d = pos_q + 3'd1;
				end else begin
					pos_d = '0;
					if (tag_q == rcd_pkg::TagRiff || tag_q == rcd_pkg::TagList) begin
						phase_d = rcd_pkg::PH_FORM;
					end else begin
						kind_d = rcd_pkg::classify(tag_q);
						rem_d  = size_d;
						if (size_d == '0) begin
							// An empty chunk still yields one marker transaction.
							phase_d             = rcd_pkg::PH_HEADER;
							produce             = 1'b1;
							result.chunk_kind   = kind_d;
							result.chunk_length = size_d;
							result.payload_byte = '0;
							result.byte_valid   = 1'b0;
							result.chunk_last   = 1'b1;
						end else begin
							phase_d = rcd_pkg::PH_PAYLOAD;
						end
					end
				end
			end
			rcd_pkg::PH_FORM: begin
				if (pos_q != LastFormPos) begin
					pos_d = pos_q + 3'd1;
				end else begin
					pos_d   = '0;
					phase_d = rcd_pkg::PH_HEADER;
				end
			end
			rcd_pkg::PH_PAYLOAD: begin
				rem_d   = rem_q - 32'd1;
				produce = 1'b1;
				if (rem_d == '0) begin
					result.chunk_last = 1'b1;
					pos_d             = '0;
					phase_d           = size_q[0] ? rcd_pkg::PH_PAD : rcd_pkg::PH_HEADER;
				end
			end
			default: begin
				pos_d   = '0;
				phase_d = rcd_pkg::PH_HEADER;
			end
		endcase
	end

endmodule

@@ design/rcd_out_reg.sv @@
module rcd_out_reg (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  rcd_pkg::chunk_result_t result,
	output logic                   slot_free,
	rcd_chunk_if.source            chunk
);

	logic                   valid_q;
	rcd_pkg::chunk_result_t data_q;

	assign slot_free = !valid_q || chunk.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (chunk.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= result;
		end
	end

	assign chunk.valid        = valid_q;
	assign chunk.chunk_kind   = data_q.chunk_kind;
	assign chunk.chunk_tag    = data_q.chunk_tag;
	assign chunk.chunk_length = data_q.chunk_length;
	assign chunk.payload_byte = data_q.payload_byte;
	assign chunk.byte_valid   = data_q.byte_valid;
	assign chunk.chunk_last   = data_q.chunk_last;

endmodule
